// ===== design/rmj_pkg.sv =====
// shared types and constants for the radar measurement jacobian block
package rmj_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W = 16;
  localparam logic [CFG_W-1:0] CFG_RESET = 16'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
  } state_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_by_x;
    logic signed [DATA_W-1:0] range_by_y;
    logic signed [DATA_W-1:0] bearing_by_x;
    logic signed [DATA_W-1:0] bearing_by_y;
    logic signed [DATA_W-1:0] rate_by_x;
    logic signed [DATA_W-1:0] rate_by_y;
    logic                     near_origin;
  } jac_out_t;

endpackage

// ===== design/rmj_sqrt.sv =====
// pipelined floor square root, one root bit per stage
module rmj_sqrt #(
  parameter int RW = 32
) (
  input  logic            clk_i,
  input  logic [2*RW-1:0] val_i,
  output logic [RW-1:0]   root_o
);

  logic [2*RW-1:0] rem_q  [RW];
  logic [RW-1:0]   root_q [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam int B = RW - 1 - i;
    logic [2*RW-1:0] rem_in, trial, rem_d;
    logic [RW-1:0]   root_in, root_d;

    if (i == 0) begin : g_first
      assign rem_in  = val_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    always_comb begin
      // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
      trial  = ({{RW{1'b0}}, root_in} << (B + 1)) | ((2*RW)'(1) << (2 * B));
      rem_d  = rem_in;
      root_d = root_in;
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = root_in | (RW'(1) << B);
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= rem_d;
      root_q[i] <= root_d;
    end
  end

  assign root_o = root_q[RW-1];

endmodule

// ===== design/rmj_div.sv =====
// pipelined restoring divider, overflow check then one quotient bit per stage
module rmj_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 32
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o,
  output logic          big_o
);

  localparam int RW = DW + QW;
  localparam int CW = (NW > RW) ? NW : RW;

  logic [RW-1:0] rem_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          big_q [QW+1];

  // quotient does not fit in QW bits when num >= den * 2^QW
  always_ff @(posedge clk_i) begin
    big_q[0] <= CW'(num_i) >= (CW'(den_i) << QW);
    rem_q[0] <= RW'(num_i);
    den_q[0] <= den_i;
    quo_q[0] <= '0;
  end

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int B = QW - 1 - i;
    logic [RW-1:0] dsh, rem_d;
    logic [QW-1:0] quo_d;

    always_comb begin
      dsh   = {{QW{1'b0}}, den_q[i]} << B;
      rem_d = rem_q[i];
      quo_d = quo_q[i];
      if (rem_q[i] >= dsh) begin
        rem_d = rem_q[i] - dsh;
        quo_d = quo_q[i] | (QW'(1) << B);
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i+1] <= rem_d;
      den_q[i+1] <= den_q[i];
      quo_q[i+1] <= quo_d;
      big_q[i+1] <= big_q[i];
    end
  end

  assign quo_o = quo_q[QW];
  assign big_o = big_q[QW];

endmodule

// ===== design/radar_measurement_jacobian_top.sv =====
// radar measurement jacobian: pipelined top level
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+-------------------------------
//  state in | in_data_i                     | start & !busy (busy stays low)
//  result   | res_o                         | strobe_o, one cycle, no stall
//  config   | cfg_wdata_i                   | cfg_we_i
//
// one beat enters every cycle; each result passes stages 1 to 4, the W stages
// of the sqrt, stages 5 and 6, the W+1 divider stages and the output register.
// reset clears the valid line and loads the threshold with its reset value.
// nothing stalls: results are shown for one cycle and busy never rises.
module radar_measurement_jacobian_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  rmj_pkg::state_in_t             in_data_i,
  output logic                           strobe_o,
  output rmj_pkg::jac_out_t              res_o,
  input  logic                           cfg_we_i,
  input  logic [rmj_pkg::CFG_W-1:0]      cfg_wdata_i
);

  localparam int W    = rmj_pkg::DATA_W;
  localparam int F    = FRAC_BITS;
  localparam int LAT  = 2 * W + 8;
  localparam int TW   = rmj_pkg::CFG_W + F;
  localparam int CMPW = (2 * W > TW) ? 2 * W : TW;

  typedef struct packed {
    logic [W-1:0]   xm;
    logic [W-1:0]   ym;
    logic           xn;
    logic           yn;
    logic           cn;
    logic           near;
    logic [2*W-1:0] r2;
    logic [2*W-1:0] cm;
  } ctx_t;

  typedef struct packed {
    logic xn;
    logic yn;
    logic cn;
    logic near;
  } sgn_t;

  logic [rmj_pkg::CFG_W-1:0] min_r2_q;
  logic [LAT-1:0]            valid_q;
  logic                      accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_r2_q <= rmj_pkg::CFG_RESET;
      valid_q  <= '0;
    end else begin
      if (cfg_we_i) min_r2_q <= cfg_wdata_i;
      valid_q <= {valid_q[LAT-2:0], accept};
    end
  end

  // stage 1: magnitudes and signs
  logic [W-1:0] s1_xm_q, s1_ym_q, s1_vxm_q, s1_vym_q;
  logic         s1_xn_q, s1_yn_q, s1_vxn_q, s1_vyn_q;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  always_ff @(posedge clk_i) begin
    s1_xm_q  <= mag(in_data_i.pos_x);
    s1_ym_q  <= mag(in_data_i.pos_y);
    s1_vxm_q <= mag(in_data_i.vel_x);
    s1_vym_q <= mag(in_data_i.vel_y);
    s1_xn_q  <= in_data_i.pos_x[W-1];
    s1_yn_q  <= in_data_i.pos_y[W-1];
    s1_vxn_q <= in_data_i.vel_x[W-1];
    s1_vyn_q <= in_data_i.vel_y[W-1];
  end

  // stage 2: squares and cross products
  logic [2*W-1:0] s2_xx_q, s2_yy_q, s2_p_q, s2_q_q;
  logic           s2_pn_q, s2_qn_q, s2_xn_q, s2_yn_q;
  logic [W-1:0]   s2_xm_q, s2_ym_q;

  always_ff @(posedge clk_i) begin
    s2_xx_q <= s1_xm_q * s1_xm_q;
    s2_yy_q <= s1_ym_q * s1_ym_q;
    s2_p_q  <= s1_vxm_q * s1_ym_q;
    s2_q_q  <= s1_vym_q * s1_xm_q;
    s2_pn_q <= s1_vxn_q ^ s1_yn_q;
    s2_qn_q <= s1_vyn_q ^ s1_xn_q;
    s2_xm_q <= s1_xm_q;
    s2_ym_q <= s1_ym_q;
    s2_xn_q <= s1_xn_q;
    s2_yn_q <= s1_yn_q;
  end

  // stage 3: r squared, threshold, signed cross difference
  logic [2*W-1:0]        s3_r2_d;
  logic signed [2*W+1:0] s3_ps, s3_qs;
  logic [2*W-1:0]        s3_r2_q;
  logic signed [2*W+1:0] s3_c_q;
  logic                  s3_near_q, s3_xn_q, s3_yn_q;
  logic [W-1:0]          s3_xm_q, s3_ym_q;

  always_comb begin
    s3_r2_d = s2_xx_q + s2_yy_q;
    s3_ps   = s2_pn_q ? -$signed({2'b00, s2_p_q}) : $signed({2'b00, s2_p_q});
    s3_qs   = s2_qn_q ? -$signed({2'b00, s2_q_q}) : $signed({2'b00, s2_q_q});
  end

  always_ff @(posedge clk_i) begin
    s3_r2_q   <= s3_r2_d;
    s3_near_q <= (s3_r2_d == '0) || (CMPW'(s3_r2_d) < (CMPW'(min_r2_q) << F));
    s3_c_q    <= s3_ps - s3_qs;
    s3_xm_q   <= s2_xm_q;
    s3_ym_q   <= s2_ym_q;
    s3_xn_q   <= s2_xn_q;
    s3_yn_q   <= s2_yn_q;
  end

  // stage 4: magnitude of the cross difference
  ctx_t s4_ctx_q;

  always_ff @(posedge clk_i) begin
    s4_ctx_q.xm   <= s3_xm_q;
    s4_ctx_q.ym   <= s3_ym_q;
    s4_ctx_q.xn   <= s3_xn_q;
    s4_ctx_q.yn   <= s3_yn_q;
    s4_ctx_q.cn   <= s3_c_q[2*W+1];
    s4_ctx_q.near <= s3_near_q;
    s4_ctx_q.r2   <= s3_r2_q;
    s4_ctx_q.cm   <= s3_c_q[2*W+1] ? (2*W)'(-s3_c_q) : s3_c_q[2*W-1:0];
  end

  // square root, context waits alongside
  logic [W-1:0] r_root;
  ctx_t         ctx_line_q [W];

  rmj_sqrt #(.RW(W)) u_sqrt (
    .clk_i  (clk_i),
    .val_i  (s4_ctx_q.r2),
    .root_o (r_root)
  );

  always_ff @(posedge clk_i) begin
    ctx_line_q[0] <= s4_ctx_q;
    for (int i = 1; i < W; i++) ctx_line_q[i] <= ctx_line_q[i-1];
  end

  // stage 5: partial products of r^3, y*c and x*c
  ctx_t         s5_ctx_q;
  logic [W-1:0] s5_r_q;
  logic [2*W-1:0] s5_r3h_q, s5_r3l_q, s5_nxh_q, s5_nxl_q, s5_nyh_q, s5_nyl_q;

  always_ff @(posedge clk_i) begin
    s5_ctx_q <= ctx_line_q[W-1];
    s5_r_q   <= r_root;
    s5_r3h_q <= ctx_line_q[W-1].r2[2*W-1:W] * r_root;
    s5_r3l_q <= ctx_line_q[W-1].r2[W-1:0] * r_root;
    s5_nxh_q <= ctx_line_q[W-1].cm[2*W-1:W] * ctx_line_q[W-1].ym;
    s5_nxl_q <= ctx_line_q[W-1].cm[W-1:0] * ctx_line_q[W-1].ym;
    s5_nyh_q <= ctx_line_q[W-1].cm[2*W-1:W] * ctx_line_q[W-1].xm;
    s5_nyl_q <= ctx_line_q[W-1].cm[W-1:0] * ctx_line_q[W-1].xm;
  end

  // stage 6: partial product sums
  ctx_t           s6_ctx_q;
  logic [W-1:0]   s6_r_q;
  logic [3*W-1:0] s6_r3_q, s6_nx_q, s6_ny_q;

  always_ff @(posedge clk_i) begin
    s6_ctx_q <= s5_ctx_q;
    s6_r_q   <= s5_r_q;
    s6_r3_q  <= ({s5_r3h_q, {W{1'b0}}}) + (3*W)'(s5_r3l_q);
    s6_nx_q  <= ({s5_nxh_q, {W{1'b0}}}) + (3*W)'(s5_nxl_q);
    s6_ny_q  <= ({s5_nyh_q, {W{1'b0}}}) + (3*W)'(s5_nyl_q);
  end

  // six quotients
  logic [W-1:0] q_rx, q_ry, q_bx, q_by, q_tx, q_ty;
  logic         b_rx, b_ry, b_bx, b_by, b_tx, b_ty;

  rmj_div #(.NW(W + F), .DW(W), .QW(W)) u_div_rx (
    .clk_i(clk_i), .num_i({s6_ctx_q.xm, {F{1'b0}}}), .den_i(s6_r_q),
    .quo_o(q_rx), .big_o(b_rx));
  rmj_div #(.NW(W + F), .DW(W), .QW(W)) u_div_ry (
    .clk_i(clk_i), .num_i({s6_ctx_q.ym, {F{1'b0}}}), .den_i(s6_r_q),
    .quo_o(q_ry), .big_o(b_ry));
  rmj_div #(.NW(W + 2 * F), .DW(2 * W), .QW(W)) u_div_bx (
    .clk_i(clk_i), .num_i({s6_ctx_q.ym, {(2*F){1'b0}}}), .den_i(s6_ctx_q.r2),
    .quo_o(q_bx), .big_o(b_bx));
  rmj_div #(.NW(W + 2 * F), .DW(2 * W), .QW(W)) u_div_by (
    .clk_i(clk_i), .num_i({s6_ctx_q.xm, {(2*F){1'b0}}}), .den_i(s6_ctx_q.r2),
    .quo_o(q_by), .big_o(b_by));
  rmj_div #(.NW(3 * W + F), .DW(3 * W), .QW(W)) u_div_tx (
    .clk_i(clk_i), .num_i({s6_nx_q, {F{1'b0}}}), .den_i(s6_r3_q),
    .quo_o(q_tx), .big_o(b_tx));
  rmj_div #(.NW(3 * W + F), .DW(3 * W), .QW(W)) u_div_ty (
    .clk_i(clk_i), .num_i({s6_ny_q, {F{1'b0}}}), .den_i(s6_r3_q),
    .quo_o(q_ty), .big_o(b_ty));

  sgn_t sgn_line_q [W+1];

  always_ff @(posedge clk_i) begin
    sgn_line_q[0] <= '{xn: s6_ctx_q.xn, yn: s6_ctx_q.yn, cn: s6_ctx_q.cn,
                       near: s6_ctx_q.near};
    for (int i = 1; i <= W; i++) sgn_line_q[i] <= sgn_line_q[i-1];
  end

  // saturate the magnitude to the signed range, then apply the sign; zero near the origin
  function automatic logic [W-1:0] sat(input logic [W-1:0] q, input logic big,
                                       input logic neg, input logic near);
    logic [W-1:0] lim, v;
    lim = neg ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
    v   = (big || (q > lim)) ? lim : q;
    v   = neg ? (~v + W'(1)) : v;
    return near ? '0 : v;
  endfunction

  sgn_t               sg;
  rmj_pkg::jac_out_t  res_q;

  assign sg = sgn_line_q[W];

  always_ff @(posedge clk_i) begin
    res_q.range_by_x   <= sat(q_rx, b_rx, sg.xn, sg.near);
    res_q.range_by_y   <= sat(q_ry, b_ry, sg.yn, sg.near);
    res_q.bearing_by_x <= sat(q_bx, b_bx, !sg.yn, sg.near);
    res_q.bearing_by_y <= sat(q_by, b_by, sg.xn, sg.near);
    res_q.rate_by_x    <= sat(q_tx, b_tx, sg.yn ^ sg.cn, sg.near);
    res_q.rate_by_y    <= sat(q_ty, b_ty, !(sg.xn ^ sg.cn), sg.near);
    res_q.near_origin  <= sg.near;
  end

  assign res_o    = res_q;
  assign strobe_o = valid_q[LAT-1];

  // a near-origin beat carries only zeros
  a_near_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && res_o.near_origin |-> res_o.range_by_x == '0 &&
      res_o.range_by_y == '0 && res_o.bearing_by_x == '0 &&
      res_o.bearing_by_y == '0 && res_o.rate_by_x == '0 && res_o.rate_by_y == '0)
    else $error("near-origin result not zero");

  // every result comes from an earlier accepted beat
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(accept, LAT))
    else $error("result without an accepted beat");

  // range entry keeps the sign of x
  a_range_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !res_o.near_origin |->
      (res_o.range_by_x[W-1] == $past(in_data_i.pos_x[W-1], LAT)) ||
      (res_o.range_by_x == '0))
    else $error("range entry sign mismatch");

endmodule

// ===== tb/tb_top.sv =====
// testbench for the radar measurement jacobian: directed and random states checked in order
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int LAT = 2 * rmj_pkg::DATA_W + 8;
  localparam int LIMIT = 300000;

  class jacobian_board;
    rmj_pkg::jac_out_t pending[$];
    logic [rmj_pkg::CFG_W-1:0] min_r2;
    int errors;

    function new();
      min_r2 = rmj_pkg::CFG_RESET;
      errors = 0;
    endfunction

    function bit [255:0] magnitude(logic [rmj_pkg::DATA_W-1:0] v);
      logic [rmj_pkg::DATA_W-1:0] m;
      m = v[rmj_pkg::DATA_W-1] ? -v : v;
      return {224'b0, m};
    endfunction

    // (mag << sh) / den toward zero, saturated to the signed range
    function logic [rmj_pkg::DATA_W-1:0] quotient(bit [255:0] mag, bit neg, int sh,
                                                  bit [255:0] den);
      bit [255:0] q, lim;
      logic [rmj_pkg::DATA_W-1:0] v;
      q = (mag << sh) / den;
      lim = neg ? (256'd1 << (rmj_pkg::DATA_W - 1)) : ((256'd1 << (rmj_pkg::DATA_W - 1)) - 1);
      if (q > lim) q = lim;
      v = q[rmj_pkg::DATA_W-1:0];
      return neg ? -v : v;
    endfunction

    function rmj_pkg::jac_out_t jacobian(rmj_pkg::state_in_t s);
      rmj_pkg::jac_out_t o;
      bit [255:0] xm, ym, vxm, vym, r2, r, r3, t, cm;
      bit xn, yn, vxn, vyn, cn;
      logic signed [257:0] sp, sq, sc;
      xm = magnitude(s.pos_x);  xn = s.pos_x[rmj_pkg::DATA_W-1];
      ym = magnitude(s.pos_y);  yn = s.pos_y[rmj_pkg::DATA_W-1];
      vxm = magnitude(s.vel_x); vxn = s.vel_x[rmj_pkg::DATA_W-1];
      vym = magnitude(s.vel_y); vyn = s.vel_y[rmj_pkg::DATA_W-1];
      o = '0;
      r2 = xm * xm + ym * ym;
      if (r2 == 0 || r2 < ({240'b0, min_r2} << FRAC)) begin
        o.near_origin = 1'b1;
        return o;
      end
      r = 0;
      for (int b = 127; b >= 0; b--) begin
        t = r | (256'd1 << b);
        if (t * t <= r2) r = t;
      end
      r3 = r2 * r;
      sp = $signed({2'b0, vxm * ym});
      if (vxn ^ yn) sp = -sp;
      sq = $signed({2'b0, vym * xm});
      if (vyn ^ xn) sq = -sq;
      sc = sp - sq;
      cn = sc < 0;
      cm = cn ? 256'(-sc) : 256'(sc);
      o.range_by_x = quotient(xm, xn, FRAC, r);
      o.range_by_y = quotient(ym, yn, FRAC, r);
      o.bearing_by_x = quotient(ym, !yn, 2 * FRAC, r2);
      o.bearing_by_y = quotient(xm, xn, 2 * FRAC, r2);
      o.rate_by_x = quotient(ym * cm, yn ^ cn, FRAC, r3);
      o.rate_by_y = quotient(xm * cm, !(xn ^ cn), FRAC, r3);
      return o;
    endfunction

    function void note_state(rmj_pkg::state_in_t s);
      pending.push_back(jacobian(s));
    endfunction

    task report_mismatch(string what, logic [rmj_pkg::DATA_W-1:0] got,
                         logic [rmj_pkg::DATA_W-1:0] exp);
      $display("mismatch %s: got %h expected %h", what, got, exp);
      errors++;
    endtask

    task check_result(rmj_pkg::jac_out_t got);
      rmj_pkg::jac_out_t e;
      if (pending.size() == 0) begin
        report_mismatch("result beat with nothing expected", '0, '0);
        return;
      end
      e = pending.pop_front();
      if (got.range_by_x !== e.range_by_x) report_mismatch("range_by_x", got.range_by_x, e.range_by_x);
      if (got.range_by_y !== e.range_by_y) report_mismatch("range_by_y", got.range_by_y, e.range_by_y);
      if (got.bearing_by_x !== e.bearing_by_x)
        report_mismatch("bearing_by_x", got.bearing_by_x, e.bearing_by_x);
      if (got.bearing_by_y !== e.bearing_by_y)
        report_mismatch("bearing_by_y", got.bearing_by_y, e.bearing_by_y);
      if (got.rate_by_x !== e.rate_by_x) report_mismatch("rate_by_x", got.rate_by_x, e.rate_by_x);
      if (got.rate_by_y !== e.rate_by_y) report_mismatch("rate_by_y", got.rate_by_y, e.rate_by_y);
      if (got.near_origin !== e.near_origin)
        report_mismatch("near_origin", rmj_pkg::DATA_W'(got.near_origin),
                        rmj_pkg::DATA_W'(e.near_origin));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  rmj_pkg::state_in_t in_data_i = '0;
  logic strobe_o;
  rmj_pkg::jac_out_t res_o;
  logic cfg_we_i = 1'b0;
  logic [rmj_pkg::CFG_W-1:0] cfg_wdata_i = '0;
  int cycles = 0;
  int gap_pct = 0;
  jacobian_board board = new();

  always #5 clk_i = ~clk_i;

  radar_measurement_jacobian_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_data_i(in_data_i),
    .strobe_o(strobe_o), .res_o(res_o), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_ni) begin
      if (start && !busy) board.note_state(in_data_i);
      if (strobe_o) board.check_result(res_o);
    end
  end

  // holds the beat until accepted, then maybe idles for a while
  task automatic send_state(rmj_pkg::state_in_t s);
    int n;
    start <= 1'b1;
    in_data_i <= s;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      n = $urandom_range(8, 1);
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LAT + 8) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [rmj_pkg::CFG_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.min_r2 = v;
    @(posedge clk_i);
  endtask

  function automatic logic [rmj_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return $urandom_range(16'hffff) - 32'sd32768;
      3: return $signed($urandom_range(64)) - 32'sd32;
      4: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
      default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  task automatic random_states(int n);
    rmj_pkg::state_in_t s;
    repeat (n) begin
      s.pos_x = pick_value();
      s.pos_y = pick_value();
      s.vel_x = $urandom_range(3) == 0 ? pick_value() : $urandom;
      s.vel_y = $urandom_range(3) == 0 ? pick_value() : $urandom;
      send_state(s);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: origin, threshold edge, field extremes, saturation
    send_state('{0, 0, 32'h7fff_ffff, 32'h8000_0000});
    send_state('{32'sh2a0, 0, 1, 1});
    send_state('{32'sh2a6, 0, 1, 1});
    send_state('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    send_state('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff});
    send_state('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000});
    send_state('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff});
    send_state('{32'sh10000, 0, 0, 32'sh10000});
    send_state('{0, -32'sh10000, 32'sh10000, 0});
    send_state('{32'sh30000, 32'sh40000, -32'sh20000, 32'sh50000});
    send_state('{-32'sh300, 32'sh300, 32'sh7fff_ffff, 32'sh8000_0000});
    send_state('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    drain();
    write_threshold(16'd0);
    send_state('{1, 0, 32'sh7fff_ffff, 0});
    send_state('{-1, 0, 0, 32'sh8000_0000});
    send_state('{0, 1, 32'sh8000_0000, 32'sh7fff_ffff});
    send_state('{1, -1, 32'sh7fff_ffff, 32'sh7fff_ffff});
    send_state('{0, 0, 1, 1});
    drain();
    write_threshold(16'hffff);
    send_state('{32'sh00ff_0000, 0, 1, 1});
    send_state('{32'sh0100_0000, 0, 1, 1});
    send_state('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 1});

    gap_pct = 0;
    random_states(160);
    drain();
    write_threshold(rmj_pkg::CFG_RESET);
    gap_pct = 64;
    random_states(160);
    drain();
    write_threshold(16'($urandom));
    gap_pct = 0;
    random_states(160);
    drain();
    write_threshold(16'd1);
    gap_pct = 15;
    random_states(170);
    drain();

    if (board.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// ===== files.f =====
design/rmj_pkg.sv
design/rmj_sqrt.sv
design/rmj_div.sv
design/radar_measurement_jacobian_top.sv
tb/tb_top.sv
